@@ hdl/volume_block_average_shrink_macros.svh @@
// Assertion macros for the volume block averaging block.
// Included by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef VOLUME_BLOCK_AVERAGE_SHRINK_MACROS_SVH
`define VOLUME_BLOCK_AVERAGE_SHRINK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VBAS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("volume block average: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define VBAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("volume block average: next-cycle check failed");

`endif

@@ hdl/vbas_pkg.sv @@
// Shared types, constants and helper functions of the volume block averaging block.
// Used by every module of the block except vbas_ram; depends on nothing.
`default_nettype none

package vbas_pkg;

    // Size limits of the block.
    localparam int MAX_SIZE    = 1024;
    localparam int MAX_FACTOR  = 16;
    localparam int SAMPLE_BITS = 16;

    // Derived widths.
    localparam int POS_W     = $clog2(MAX_SIZE);
    localparam int SIZE_W    = POS_W + 1;
    localparam int INB_W     = $clog2(MAX_FACTOR);
    localparam int FAC_W     = INB_W + 1;
    localparam int SUM_W     = SAMPLE_BITS + 3 * INB_W;
    localparam int FXY_W     = 2 * INB_W + 1;
    localparam int N_W       = 3 * INB_W + 1;
    localparam int FRAC_BITS = 8;
    localparam int AVG_W     = 24;
    localparam int Q_W       = AVG_W + 1;
    localparam int DVD_W     = SUM_W + FRAC_BITS + 1;
    localparam int STEP_W    = $clog2(DVD_W);
    localparam int OUT_DATA_W = ((AVG_W + 3 * POS_W + 7) / 8) * 8;
    localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_FACTOR_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FACTOR_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FACTOR_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_X   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Y   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Z   = 3'd5;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV,
        ST_EMIT
    } t_state;

    // Effective configuration seen by the datapath.
    typedef struct packed {
        logic [FAC_W-1:0]  fac_x;
        logic [FAC_W-1:0]  fac_y;
        logic [FAC_W-1:0]  fac_z;
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
        logic              restart;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic accum;
        logic div_step;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic voxel_ok;
        logic blk_last;
        logic div_last;
        logic out_free;
    } t_dp_status;

    // A zero factor counts as one; larger factors saturate.
    function automatic logic [FAC_W-1:0] eff_factor(input logic [FAC_W-1:0] f);
        logic [FAC_W-1:0] r;
        if (f == '0) begin
            r = FAC_W'(1);
        end else if (f > FAC_W'(MAX_FACTOR)) begin
            r = FAC_W'(MAX_FACTOR);
        end else begin
            r = f;
        end
        return r;
    endfunction

    // A zero size counts as one; larger sizes saturate.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        if (s == '0) begin
            r = SIZE_W'(1);
        end else if (s > SIZE_W'(MAX_SIZE)) begin
            r = SIZE_W'(MAX_SIZE);
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/vbas_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Standalone; depends on nothing.
`default_nettype none

module vbas_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/vbas_regs.sv @@
// Configuration registers behind the APB-style port, with effective value clamping.
// Depends on vbas_pkg.
`default_nettype none

module vbas_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_psel,
    input  wire logic                              i_penable,
    input  wire logic                              i_pwrite,
    input  wire logic [vbas_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  wire logic [vbas_pkg::APB_DATA_W-1:0]   i_pwdata,
    output logic      [vbas_pkg::APB_DATA_W-1:0]   o_prdata,
    output logic                                   o_pready,
    output vbas_pkg::t_cfg                         o_cfg
);

    logic [vbas_pkg::FAC_W-1:0]  r_fac_x, r_fac_y, r_fac_z;
    logic [vbas_pkg::SIZE_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [vbas_pkg::REG_IDX_W-1:0] w_idx;
    logic w_write;
    logic w_known;

    assign w_idx    = i_paddr[vbas_pkg::APB_ADDR_W-1:2];
    assign w_write  = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    // Register writes; reset gives unit factors and full-size volumes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fac_x  <= vbas_pkg::FAC_W'(1);
            r_fac_y  <= vbas_pkg::FAC_W'(1);
            r_fac_z  <= vbas_pkg::FAC_W'(1);
            r_size_x <= vbas_pkg::SIZE_W'(vbas_pkg::MAX_SIZE);
            r_size_y <= vbas_pkg::SIZE_W'(vbas_pkg::MAX_SIZE);
            r_size_z <= vbas_pkg::SIZE_W'(vbas_pkg::MAX_SIZE);
        end else if (w_write) begin
            case (w_idx)
                vbas_pkg::REG_FACTOR_X: r_fac_x  <= i_pwdata[vbas_pkg::FAC_W-1:0];
                vbas_pkg::REG_FACTOR_Y: r_fac_y  <= i_pwdata[vbas_pkg::FAC_W-1:0];
                vbas_pkg::REG_FACTOR_Z: r_fac_z  <= i_pwdata[vbas_pkg::FAC_W-1:0];
                vbas_pkg::REG_SIZE_X:   r_size_x <= i_pwdata[vbas_pkg::SIZE_W-1:0];
                vbas_pkg::REG_SIZE_Y:   r_size_y <= i_pwdata[vbas_pkg::SIZE_W-1:0];
                vbas_pkg::REG_SIZE_Z:   r_size_z <= i_pwdata[vbas_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data mux and known-register decode.
    always_comb begin
        o_prdata = '0;
        w_known  = 1'b1;
        case (w_idx)
            vbas_pkg::REG_FACTOR_X: o_prdata = vbas_pkg::APB_DATA_W'(r_fac_x);
            vbas_pkg::REG_FACTOR_Y: o_prdata = vbas_pkg::APB_DATA_W'(r_fac_y);
            vbas_pkg::REG_FACTOR_Z: o_prdata = vbas_pkg::APB_DATA_W'(r_fac_z);
            vbas_pkg::REG_SIZE_X:   o_prdata = vbas_pkg::APB_DATA_W'(r_size_x);
            vbas_pkg::REG_SIZE_Y:   o_prdata = vbas_pkg::APB_DATA_W'(r_size_y);
            vbas_pkg::REG_SIZE_Z:   o_prdata = vbas_pkg::APB_DATA_W'(r_size_z);
            default:                w_known  = 1'b0;
        endcase
    end

    // Effective values; any write to a known register restarts the volume.
    always_comb begin
        o_cfg.fac_x   = vbas_pkg::eff_factor(r_fac_x);
        o_cfg.fac_y   = vbas_pkg::eff_factor(r_fac_y);
        o_cfg.fac_z   = vbas_pkg::eff_factor(r_fac_z);
        o_cfg.size_x  = vbas_pkg::eff_size(r_size_x);
        o_cfg.size_y  = vbas_pkg::eff_size(r_size_y);
        o_cfg.size_z  = vbas_pkg::eff_size(r_size_z);
        o_cfg.restart = w_write && w_known;
    end

endmodule

`default_nettype wire

@@ hdl/vbas_ctrl.sv @@
// Controller state machine: sequences take, accumulate, divide and emit.
// Depends on vbas_pkg.
`default_nettype none

module vbas_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  vbas_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output vbas_pkg::t_dp_cmd    o_cmd
);

    vbas_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vbas_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state. Dropped voxels stay in idle.
    always_comb begin
        n_state = r_state;
        case (r_state)
            vbas_pkg::ST_IDLE: begin
                if (i_in_valid && i_status.voxel_ok) begin
                    n_state = vbas_pkg::ST_ACCUM;
                end
            end
            vbas_pkg::ST_ACCUM: begin
                n_state = i_status.blk_last ? vbas_pkg::ST_DIV : vbas_pkg::ST_IDLE;
            end
            vbas_pkg::ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = vbas_pkg::ST_EMIT;
                end
            end
            vbas_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = vbas_pkg::ST_IDLE;
                end
            end
            default: n_state = vbas_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.take     = 1'b0;
        o_cmd.accum    = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.emit     = 1'b0;
        case (r_state)
            vbas_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            vbas_pkg::ST_ACCUM: o_cmd.accum    = 1'b1;
            vbas_pkg::ST_DIV:   o_cmd.div_step = 1'b1;
            vbas_pkg::ST_EMIT:  o_cmd.emit     = i_status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/vbas_dp.sv @@
// Datapath: position counters, column accumulator memory, rounding divider, output register.
// Depends on vbas_pkg and vbas_ram.
`default_nettype none

module vbas_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  vbas_pkg::t_cfg                           i_cfg,
    input  vbas_pkg::t_dp_cmd                        i_cmd,
    output vbas_pkg::t_dp_status                     o_status,
    input  wire logic [vbas_pkg::SAMPLE_BITS-1:0]    i_sample,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [vbas_pkg::AVG_W-1:0]          o_average,
    output logic      [vbas_pkg::POS_W-1:0]          o_out_x,
    output logic      [vbas_pkg::POS_W-1:0]          o_out_y,
    output logic      [vbas_pkg::POS_W-1:0]          o_out_z,
    output logic                                     o_volume_done
);

    localparam int POS_W  = vbas_pkg::POS_W;
    localparam int SIZE_W = vbas_pkg::SIZE_W;
    localparam int INB_W  = vbas_pkg::INB_W;
    localparam int FAC_W  = vbas_pkg::FAC_W;
    localparam int SUM_W  = vbas_pkg::SUM_W;
    localparam int N_W    = vbas_pkg::N_W;
    localparam int Q_W    = vbas_pkg::Q_W;
    localparam int DVD_W  = vbas_pkg::DVD_W;
    localparam int AVG_W  = vbas_pkg::AVG_W;
    localparam int EXT_W  = SIZE_W + 1;
    localparam int SB     = vbas_pkg::SAMPLE_BITS;

    // Position state.
    logic [POS_W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [INB_W-1:0] r_inb_x, r_inb_y, r_inb_z;
    logic [POS_W-1:0] r_col, r_oy, r_oz;
    logic [POS_W-1:0] n_pos_x, n_pos_y, n_pos_z;
    logic [INB_W-1:0] n_inb_x, n_inb_y, n_inb_z;
    logic [POS_W-1:0] n_col, n_oy, n_oz;

    // Latched voxel.
    logic [SB-1:0]    r_sample;
    logic [POS_W-1:0] r_l_col, r_l_oy, r_l_oz;
    logic             r_first, r_last, r_done;

    // Divider.
    logic [vbas_pkg::FXY_W-1:0] r_fxy;
    logic [N_W-1:0]   r_n;
    logic [DVD_W-1:0] r_dvd;
    logic [N_W-1:0]   r_rem;
    logic [Q_W-1:0]   r_quo;
    logic [vbas_pkg::STEP_W-1:0] r_step;
    logic             r_neg;

    // Output register.
    logic             r_out_valid;
    logic [AVG_W-1:0] r_avg;
    logic [POS_W-1:0] r_ox_o, r_oy_o, r_oz_o;
    logic             r_done_o;

    // Axis step detection.
    logic [SIZE_W-1:0] w_x_inc, w_y_inc, w_z_inc;
    logic [FAC_W-1:0]  w_ix_inc, w_iy_inc, w_iz_inc;
    logic w_x_wrap, w_y_wrap, w_ix_wrap, w_iy_wrap, w_iz_wrap;

    assign w_x_inc  = SIZE_W'(r_pos_x) + SIZE_W'(1);
    assign w_y_inc  = SIZE_W'(r_pos_y) + SIZE_W'(1);
    assign w_z_inc  = SIZE_W'(r_pos_z) + SIZE_W'(1);
    assign w_ix_inc = FAC_W'(r_inb_x) + FAC_W'(1);
    assign w_iy_inc = FAC_W'(r_inb_y) + FAC_W'(1);
    assign w_iz_inc = FAC_W'(r_inb_z) + FAC_W'(1);
    assign w_x_wrap  = w_x_inc >= i_cfg.size_x;
    assign w_y_wrap  = w_y_inc >= i_cfg.size_y;
    assign w_ix_wrap = w_ix_inc >= i_cfg.fac_x;
    assign w_iy_wrap = w_iy_inc >= i_cfg.fac_y;
    assign w_iz_wrap = w_iz_inc >= i_cfg.fac_z;

    // Whole-block test: the block holding this voxel must end inside the volume.
    // The final-block test asks whether one more block would still fit.
    logic [EXT_W-1:0] w_end_x, w_end_y, w_end_z;
    logic [EXT_W-1:0] w_next_x, w_next_y, w_next_z;
    logic w_ok_x, w_ok_y, w_ok_z, w_fin;

    assign w_end_x  = EXT_W'(r_pos_x) - EXT_W'(r_inb_x) + EXT_W'(i_cfg.fac_x);
    assign w_end_y  = EXT_W'(r_pos_y) - EXT_W'(r_inb_y) + EXT_W'(i_cfg.fac_y);
    assign w_end_z  = EXT_W'(r_pos_z) - EXT_W'(r_inb_z) + EXT_W'(i_cfg.fac_z);
    assign w_next_x = w_end_x + EXT_W'(i_cfg.fac_x);
    assign w_next_y = w_end_y + EXT_W'(i_cfg.fac_y);
    assign w_next_z = w_end_z + EXT_W'(i_cfg.fac_z);
    assign w_ok_x = (SIZE_W'(r_pos_x) < i_cfg.size_x) && (w_end_x <= EXT_W'(i_cfg.size_x));
    assign w_ok_y = (SIZE_W'(r_pos_y) < i_cfg.size_y) && (w_end_y <= EXT_W'(i_cfg.size_y));
    assign w_ok_z = (SIZE_W'(r_pos_z) < i_cfg.size_z) && (w_end_z <= EXT_W'(i_cfg.size_z));
    assign w_fin  = (w_next_x > EXT_W'(i_cfg.size_x)) && (w_next_y > EXT_W'(i_cfg.size_y))
                 && (w_next_z > EXT_W'(i_cfg.size_z));

    // Raster advance: x fastest, y on an x wrap, z on a y wrap.
    always_comb begin
        n_pos_x = r_pos_x;  n_inb_x = r_inb_x;  n_col = r_col;
        n_pos_y = r_pos_y;  n_inb_y = r_inb_y;  n_oy  = r_oy;
        n_pos_z = r_pos_z;  n_inb_z = r_inb_z;  n_oz  = r_oz;
        if (i_cfg.restart) begin
            n_pos_x = '0;  n_inb_x = '0;  n_col = '0;
            n_pos_y = '0;  n_inb_y = '0;  n_oy  = '0;
            n_pos_z = '0;  n_inb_z = '0;  n_oz  = '0;
        end else if (i_cmd.take) begin
            if (!w_x_wrap) begin
                n_pos_x = r_pos_x + POS_W'(1);
                n_inb_x = w_ix_wrap ? '0 : w_ix_inc[INB_W-1:0];
                n_col   = w_ix_wrap ? r_col + POS_W'(1) : r_col;
            end else begin
                n_pos_x = '0;  n_inb_x = '0;  n_col = '0;
                if (!w_y_wrap) begin
                    n_pos_y = r_pos_y + POS_W'(1);
                    n_inb_y = w_iy_wrap ? '0 : w_iy_inc[INB_W-1:0];
                    n_oy    = w_iy_wrap ? r_oy + POS_W'(1) : r_oy;
                end else begin
                    n_pos_y = '0;  n_inb_y = '0;  n_oy = '0;
                    if (w_z_inc < i_cfg.size_z) begin
                        n_pos_z = r_pos_z + POS_W'(1);
                        n_inb_z = w_iz_wrap ? '0 : w_iz_inc[INB_W-1:0];
                        n_oz    = w_iz_wrap ? r_oz + POS_W'(1) : r_oz;
                    end else begin
                        n_pos_z = '0;  n_inb_z = '0;  n_oz = '0;
                    end
                end
            end
        end
    end

    // Control registers: position and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;  r_inb_x <= '0;  r_col <= '0;
            r_pos_y <= '0;  r_inb_y <= '0;  r_oy  <= '0;
            r_pos_z <= '0;  r_inb_z <= '0;  r_oz  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos_x <= n_pos_x;  r_inb_x <= n_inb_x;  r_col <= n_col;
            r_pos_y <= n_pos_y;  r_inb_y <= n_inb_y;  r_oy  <= n_oy;
            r_pos_z <= n_pos_z;  r_inb_z <= n_inb_z;  r_oz  <= n_oz;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Latch the voxel and its block flags on every taken transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sample <= i_sample;
            r_l_col  <= r_col;
            r_l_oy   <= r_oy;
            r_l_oz   <= r_oz;
            r_first  <= (r_inb_x == '0) && (r_inb_y == '0) && (r_inb_z == '0);
            r_last   <= w_ix_wrap && w_iy_wrap && w_iz_wrap;
            r_done   <= w_fin;
        end
    end

    // Column accumulator memory, read at the current column on take.
    logic [SUM_W-1:0] w_rdata, w_sum, w_sample_ext, w_mag;

    assign w_sample_ext = {{(SUM_W - SB){r_sample[SB-1]}}, r_sample};
    assign w_sum = r_first ? w_sample_ext : w_rdata + w_sample_ext;
    assign w_mag = w_sum[SUM_W-1] ? (~w_sum + SUM_W'(1)) : w_sum;

    vbas_ram #(
        .WIDTH (SUM_W),
        .DEPTH (vbas_pkg::MAX_SIZE)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accum),
        .i_waddr (r_l_col),
        .i_wdata (w_sum),
        .i_raddr (r_col),
        .o_rdata (w_rdata)
    );

    // Block voxel count, one multiply per register stage.
    logic [2*FAC_W-1:0]       w_fxy_full;
    logic [FAC_W+vbas_pkg::FXY_W-1:0] w_n_full;

    assign w_fxy_full = i_cfg.fac_x * i_cfg.fac_y;
    assign w_n_full   = r_fxy * i_cfg.fac_z;

    always_ff @(posedge i_clk) begin
        r_fxy <= w_fxy_full[vbas_pkg::FXY_W-1:0];
        r_n   <= w_n_full[N_W-1:0];
    end

    // Restoring divider, one quotient bit per step: floor(mag * 512 / n).
    logic [N_W:0]   w_trial;
    logic           w_ge;
    logic [N_W:0]   w_diff;

    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge    = w_trial >= (N_W + 1)'(r_n);
    assign w_diff  = w_trial - (N_W + 1)'(r_n);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accum && r_last) begin
            r_dvd  <= {w_mag, {(vbas_pkg::FRAC_BITS + 1){1'b0}}};
            r_rem  <= '0;
            r_quo  <= '0;
            r_step <= '0;
            r_neg  <= w_sum[SUM_W-1];
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem  <= w_ge ? w_diff[N_W-1:0] : w_trial[N_W-1:0];
            r_quo  <= {r_quo[Q_W-2:0], w_ge};
            r_step <= r_step + vbas_pkg::STEP_W'(1);
        end
    end

    // Round half up on the magnitude, then restore the sign.
    logic [Q_W-1:0]   w_q_inc;
    logic [AVG_W-1:0] w_q, w_avg;

    assign w_q_inc = r_quo + Q_W'(1);
    assign w_q     = w_q_inc[Q_W-1:1];
    assign w_avg   = r_neg ? (~w_q + AVG_W'(1)) : w_q;

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_avg    <= w_avg;
            r_ox_o   <= r_l_col;
            r_oy_o   <= r_l_oy;
            r_oz_o   <= r_l_oz;
            r_done_o <= r_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_average     = r_avg;
    assign o_out_x       = r_ox_o;
    assign o_out_y       = r_oy_o;
    assign o_out_z       = r_oz_o;
    assign o_volume_done = r_done_o;

    // Status to the controller.
    always_comb begin
        o_status.voxel_ok = w_ok_x && w_ok_y && w_ok_z;
        o_status.blk_last = r_last;
        o_status.div_last = r_step == vbas_pkg::STEP_W'(DVD_W - 1);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

endmodule

`default_nettype wire

@@ hdl/volume_block_average_shrink.sv @@
// Volume block averaging: voxels arrive in raster order (x fastest, then y, then z), one
// transaction each, and every factor_x by factor_y by factor_z block is summed in a column
// accumulator memory. The block's last voxel yields one output transaction with the mean
// (signed, 8 fraction bits, rounded half away from zero), the output coordinates and a
// volume-done flag in tlast; voxels outside the last whole block on any axis are dropped.
// A voxel is taken, then added to its column sum in the two-port column memory;
// a block-ending voxel then runs the bit-per-cycle divider (37 steps) and the emit step,
// plus any wait for the output register to drain. The next voxel is taken
// while a result waits downstream. Configuration writes restart the volume at voxel zero.
// Depends on vbas_pkg, vbas_regs, vbas_ctrl, vbas_dp, vbas_ram and the macros header.
`default_nettype none

`include "volume_block_average_shrink_macros.svh"

module volume_block_average_shrink (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input stream; tdata: sample[15:0].
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  wire logic [vbas_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // Output stream; tdata: average[23:0], out_x[33:24], out_y[43:34], out_z[53:44], zeros.
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    output logic      [vbas_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // tlast: volume_done.
    output logic                                     o_m_axis_tlast,
    // Configuration port.
    input  wire logic                                i_psel,
    input  wire logic                                i_penable,
    input  wire logic                                i_pwrite,
    input  wire logic [vbas_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  wire logic [vbas_pkg::APB_DATA_W-1:0]     i_pwdata,
    output logic      [vbas_pkg::APB_DATA_W-1:0]     o_prdata,
    output logic                                     o_pready
);

    vbas_pkg::t_cfg       w_cfg;
    vbas_pkg::t_dp_cmd    w_cmd;
    vbas_pkg::t_dp_status w_status;

    logic [vbas_pkg::AVG_W-1:0] w_average;
    logic [vbas_pkg::POS_W-1:0] w_out_x, w_out_y, w_out_z;

    vbas_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    vbas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    vbas_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_sample      (i_s_axis_tdata[vbas_pkg::SAMPLE_BITS-1:0]),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_average     (w_average),
        .o_out_x       (w_out_x),
        .o_out_y       (w_out_y),
        .o_out_z       (w_out_z),
        .o_volume_done (o_m_axis_tlast)
    );

    // Pack the output fields from the lowest bit up.
    assign o_m_axis_tdata = vbas_pkg::OUT_DATA_W'({w_out_z, w_out_y, w_out_x, w_average});

    // No input transaction is taken while the divider runs.
    `VBAS_ASSERT_NOW(a_no_take_in_div, w_cmd.div_step, !o_s_axis_tready)
    // A result is loaded only when the output register is free or draining.
    `VBAS_ASSERT_NOW(a_emit_free, w_cmd.emit, !o_m_axis_tvalid || i_m_axis_tready)
    // After an accumulation the block returns to idle or starts dividing.
    `VBAS_ASSERT_NEXT(a_accum_next, w_cmd.accum, o_s_axis_tready || w_cmd.div_step)

endmodule

`default_nettype wire

@@ tb/volume_block_average_shrink_tb.sv @@
// Self-checking testbench for volume_block_average_shrink: streams voxels with random idling,
// predicts every block mean and compares each output transaction field by field.
// Depends on vbas_pkg and the volume_block_average_shrink RTL.
`default_nettype none

module volume_block_average_shrink_tb;
    import vbas_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_VOXELS = 1200;
    localparam int RANDOM_BINS   = 48;

    // Register indexes with no register behind them.
    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [AVG_W-1:0] average;
        logic [POS_W-1:0] out_x;
        logic [POS_W-1:0] out_y;
        logic [POS_W-1:0] out_z;
        logic             volume_done;
    } bin_result_t;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_DATA_W-1:0]    i_s_axis_tdata = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   o_m_axis_tdata;
    logic                    o_m_axis_tlast;
    logic                    i_psel = 1'b0;
    logic                    i_penable = 1'b0;
    logic                    i_pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   i_paddr = '0;
    logic [APB_DATA_W-1:0]   i_pwdata = '0;
    logic [APB_DATA_W-1:0]   o_prdata;
    logic                    o_pready;

    // Shadow configuration and scan position of the predictor.
    logic [FAC_W-1:0]  cfg_fac [3];
    logic [SIZE_W-1:0] cfg_size [3];
    int unsigned       pos [3];
    int unsigned       inb [3];
    longint            col_sum [MAX_SIZE];

    bin_result_t expected_bins [$];
    bin_result_t got_bin;
    bin_result_t want_bin;
    int          error_count = 0;
    int          cycle_count = 0;
    int unsigned binned_voxels = 0;
    int unsigned predicted_bins = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;

    volume_block_average_shrink dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("volume_block_average_shrink test failed");
            $finish;
        end
    end

    // Receiver backpressure.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic int unsigned eff_fac(input logic [FAC_W-1:0] f);
        if (f == 0) return 1;
        if (f > MAX_FACTOR) return MAX_FACTOR;
        return f;
    endfunction

    function automatic int unsigned eff_size(input logic [SIZE_W-1:0] s);
        if (s == 0) return 1;
        if (s > MAX_SIZE) return MAX_SIZE;
        return s;
    endfunction

    // Accumulates one voxel into its column and queues the block mean on the block's last voxel.
    function automatic void predict_voxel(input logic signed [SAMPLE_BITS-1:0] smp);
        int unsigned fc [3];
        int unsigned sz [3];
        int unsigned nb [3];
        int unsigned col, oy, oz, blk_n, a;
        longint      sum, q;
        bit          carry;
        bin_result_t bin;
        for (a = 0; a < 3; a++) begin
            fc[a] = eff_fac(cfg_fac[a]);
            sz[a] = eff_size(cfg_size[a]);
            nb[a] = sz[a] / fc[a];
        end
        if (pos[0] < nb[0] * fc[0] && pos[1] < nb[1] * fc[1] && pos[2] < nb[2] * fc[2]) begin
            col = pos[0] / fc[0];
            if (inb[0] == 0 && inb[1] == 0 && inb[2] == 0) begin
                sum = smp;
            end else begin
                sum = col_sum[col] + smp;
            end
            col_sum[col] = sum;
            binned_voxels++;
            if (inb[0] + 1 == fc[0] && inb[1] + 1 == fc[1] && inb[2] + 1 == fc[2]) begin
                // Mean with 8 fraction bits, half away from zero.
                blk_n = fc[0] * fc[1] * fc[2];
                q = ((sum < 0 ? -sum : sum) * 512 + longint'(blk_n)) / (2 * longint'(blk_n));
                if (sum < 0) begin
                    q = -q;
                end
                oy = pos[1] / fc[1];
                oz = pos[2] / fc[2];
                bin.average = q[AVG_W-1:0];
                bin.out_x = col[POS_W-1:0];
                bin.out_y = oy[POS_W-1:0];
                bin.out_z = oz[POS_W-1:0];
                bin.volume_done = (col + 1 == nb[0] && oy + 1 == nb[1] && oz + 1 == nb[2]);
                expected_bins.push_back(bin);
                predicted_bins++;
            end
        end
        // Raster advance: x wraps into y, y wraps into z, z wraps to a new volume.
        carry = 1'b1;
        for (a = 0; a < 3; a++) begin
            if (carry) begin
                if (pos[a] + 1 >= sz[a]) begin
                    pos[a] = 0;
                    inb[a] = 0;
                end else begin
                    pos[a] = pos[a] + 1;
                    inb[a] = (inb[a] + 1 >= fc[a]) ? 0 : inb[a] + 1;
                    carry = 1'b0;
                end
            end
        end
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        if ($urandom_range(15) != 0) return $urandom_range(16'hFFFF);
        case ($urandom_range(3))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Output checker: every output transaction against the oldest expected block mean.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_bin.average = o_m_axis_tdata[AVG_W-1:0];
            got_bin.out_x = o_m_axis_tdata[AVG_W +: POS_W];
            got_bin.out_y = o_m_axis_tdata[AVG_W + POS_W +: POS_W];
            got_bin.out_z = o_m_axis_tdata[AVG_W + 2 * POS_W +: POS_W];
            got_bin.volume_done = o_m_axis_tlast;
            if (expected_bins.size() == 0) begin
                $error("unexpected output transaction: average %0d at (%0d,%0d,%0d)",
                       $signed(got_bin.average), got_bin.out_x, got_bin.out_y, got_bin.out_z);
                error_count++;
            end else begin
                want_bin = expected_bins.pop_front();
                if (got_bin.average != want_bin.average) begin
                    $error("average: expected %0d, got %0d",
                           $signed(want_bin.average), $signed(got_bin.average));
                    error_count++;
                end
                if (got_bin.out_x != want_bin.out_x) begin
                    $error("out_x: expected %0d, got %0d", want_bin.out_x, got_bin.out_x);
                    error_count++;
                end
                if (got_bin.out_y != want_bin.out_y) begin
                    $error("out_y: expected %0d, got %0d", want_bin.out_y, got_bin.out_y);
                    error_count++;
                end
                if (got_bin.out_z != want_bin.out_z) begin
                    $error("out_z: expected %0d, got %0d", want_bin.out_z, got_bin.out_z);
                    error_count++;
                end
                if (got_bin.volume_done != want_bin.volume_done) begin
                    $error("volume_done: expected %0d, got %0d",
                           want_bin.volume_done, got_bin.volume_done);
                    error_count++;
                end
            end
        end
    end

    // One voxel transaction, with random idle cycles in front of it.
    task automatic send_voxel(input logic [SAMPLE_BITS-1:0] smp);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= smp;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_voxel(smp);
    endtask

    // Stops the stream and waits until every block mean is out and the datapath is quiet.
    task automatic settle_block();
        i_s_axis_tvalid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup phase, access phase, then the bus goes idle.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= {idx, 2'b00};
        i_pwdata <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        if (idx <= REG_FACTOR_Z) begin
            cfg_fac[idx] = value[FAC_W-1:0];
        end else if (idx <= REG_SIZE_Z) begin
            cfg_size[idx - REG_SIZE_X] = value[SIZE_W-1:0];
        end
        // Any known register restarts the volume.
        if (idx <= REG_SIZE_Z) begin
            pos = '{0, 0, 0};
            inb = '{0, 0, 0};
        end
        @(posedge i_clk);
    endtask

    task automatic write_config(input int unsigned fx, fy, fz, sx, sy, sz);
        write_reg(REG_FACTOR_X, fx);
        write_reg(REG_FACTOR_Y, fy);
        write_reg(REG_FACTOR_Z, fz);
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
    endtask

    // Reset values: unit factors, so every voxel is its own block.
    task automatic test_reset_defaults();
        send_voxel(16'h7FFF);
        send_voxel(16'h8000);
        send_voxel(16'h0000);
        send_voxel(16'hFFFF);
        settle_block();
    endtask

    // Deepest blocks with the largest and smallest sample give the extreme means.
    task automatic test_extreme_means();
        write_config(1, 1, MAX_FACTOR, 1, 1, MAX_FACTOR);
        repeat (MAX_FACTOR) send_voxel(16'h7FFF);
        repeat (MAX_FACTOR) send_voxel(16'h8000);
        settle_block();
    endtask

    // Zero registers count as one; oversized ones saturate.
    task automatic test_register_corners();
        write_config(0, 0, 0, 0, 0, 0);
        repeat (3) send_voxel(rand_sample());
        settle_block();
        write_config(20, 1, 1, 1500, 1, 1);
        repeat (MAX_FACTOR) send_voxel(rand_sample());
        settle_block();
    endtask

    // A factor larger than its size leaves no whole block, so nothing comes out.
    task automatic test_no_whole_block();
        write_config(4, 1, 1, 3, 1, 1);
        repeat (6) send_voxel(rand_sample());
        settle_block();
        write_config(1, 5, 1, 2, 4, 1);
        repeat (8) send_voxel(rand_sample());
        settle_block();
    endtask

    // Writes to unused indexes keep the position; a real write restarts mid-volume.
    task automatic test_write_restart();
        write_config(2, 1, 1, 4, 1, 1);
        send_voxel(rand_sample());
        settle_block();
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        repeat (3) send_voxel(rand_sample());
        send_voxel(rand_sample());
        settle_block();
        write_reg(REG_FACTOR_X, 2);
        repeat (4) send_voxel(rand_sample());
        settle_block();
    endtask

    // Partial blocks at the end of the x and y axes are dropped; the second volume starts clean.
    task automatic test_dropped_edges();
        write_config(2, 2, 1, 5, 3, 2);
        repeat (36) send_voxel(rand_sample());
        settle_block();
    endtask

    // 1024-voxel blocks summing to +2 and -2 land exactly on half an LSB.
    task automatic test_rounding_ties();
        int pick, bias, v, vol_i;
        write_config(MAX_FACTOR, MAX_FACTOR, 4, MAX_FACTOR, MAX_FACTOR, 4);
        for (vol_i = 0; vol_i < 2; vol_i++) begin
            bias = (vol_i == 0) ? 2 : -2;
            for (v = 0; v < 512; v++) begin
                pick = int'($urandom_range(65530)) - 32764;
                send_voxel(pick[SAMPLE_BITS-1:0]);
                send_voxel((v == 0) ? SAMPLE_BITS'(bias - pick) : SAMPLE_BITS'(-pick));
            end
        end
        settle_block();
    endtask

    // Widest row with the widest blocks.
    task automatic test_full_row();
        write_config(MAX_FACTOR, 1, 1, MAX_SIZE, 1, 1);
        repeat (MAX_SIZE) send_voxel(rand_sample());
        settle_block();
    endtask

    // Random configurations, mostly small whole volumes with random content.
    task automatic test_random_volumes();
        int unsigned start_vox, start_bins, done_vox, vol, count, a;
        logic [APB_DATA_W-1:0] value;
        bit wrote;
        start_vox = binned_voxels;
        start_bins = predicted_bins;
        while (binned_voxels - start_vox < RANDOM_VOXELS ||
               predicted_bins - start_bins < RANDOM_BINS) begin
            done_vox = binned_voxels - start_vox;
            if (done_vox < RANDOM_VOXELS / 3) begin
                src_idle_pct = 8;
                sink_idle_pct = 47;
            end else if (done_vox < 2 * RANDOM_VOXELS / 3) begin
                src_idle_pct = 47;
                sink_idle_pct = 8;
            end else begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            wrote = 1'b0;
            for (a = 0; a < 6; a++) begin
                if ($urandom_range(99) < 60 || (a == 5 && !wrote)) begin
                    if (a < 3) begin
                        value = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 4);
                    end else begin
                        value = ($urandom_range(6) == 0) ? $urandom_range(2047)
                                                         : $urandom_range(1, 12);
                    end
                    write_reg(REG_FACTOR_X + a, value);
                    wrote = 1'b1;
                end
            end
            vol = eff_size(cfg_size[0]) * eff_size(cfg_size[1]) * eff_size(cfg_size[2]);
            if (vol <= 400 && $urandom_range(3) != 0) begin
                count = vol * $urandom_range(1, 2);
            end else begin
                count = $urandom_range(1, 300);
            end
            repeat (count) send_voxel(rand_sample());
            settle_block();
        end
    endtask

    initial begin
        cfg_fac = '{1, 1, 1};
        cfg_size = '{MAX_SIZE, MAX_SIZE, MAX_SIZE};
        pos = '{0, 0, 0};
        inb = '{0, 0, 0};
        src_idle_pct = 8;
        sink_idle_pct = 47;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extreme_means();
        test_register_corners();
        test_no_whole_block();
        test_write_restart();
        test_dropped_edges();
        src_idle_pct = 47;
        sink_idle_pct = 8;
        test_rounding_ties();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_full_row();
        test_random_volumes();

        src_idle_pct = 0;
        sink_idle_pct = 0;
        settle_block();
        if (error_count == 0) begin
            $display("volume_block_average_shrink test passed");
        end else begin
            $display("volume_block_average_shrink test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
